>>> rtl/rrts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and codes for the round-robin task scheduler: event codes,
// result status codes, slot state codes, slot record and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int DEF_MAX_TASKS = 8;

    // Event codes
    localparam logic [2:0] ACT_CREATE = 3'd0;
    localparam logic [2:0] ACT_RUN    = 3'd1;
    localparam logic [2:0] ACT_YIELD  = 3'd2;
    localparam logic [2:0] ACT_EXIT   = 3'd3;
    localparam logic [2:0] ACT_QUERY  = 3'd4;

    // Result status codes
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_FULL    = 2'd1;
    localparam logic [1:0] STS_NOREADY = 2'd2;
    localparam logic [1:0] STS_NOCUR   = 2'd3;

    // Slot state codes
    localparam logic [1:0] SLOT_UNUSED   = 2'd0;
    localparam logic [1:0] SLOT_READY    = 2'd1;
    localparam logic [1:0] SLOT_RUNNING  = 2'd2;
    localparam logic [1:0] SLOT_FINISHED = 2'd3;

    typedef struct packed {
        logic [1:0]  state;
        logic [31:0] switches;
        logic [47:0] runtime;
        logic [31:0] start_tick;
    } slot_rec_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;       // take in the new event
        logic set_full;      // status: table full
        logic set_nocur;     // status: no current task
        logic set_noready;   // status: no ready task
        logic create;        // fill the next slot
        logic rd_cur;        // read the running slot
        logic rd_q;          // read the queried slot
        logic latch_q;       // hold query data
        logic latch_cur;     // hold running slot record and tick delta
        logic write_cur;     // write back charged running slot
        logic exit_main;     // last task gone, return to main
        logic srch_init_run; // search from slot zero over all slots
        logic srch_init_cur; // search after the running slot
        logic srch_rd;       // read the slot under search
        logic srch_step;     // advance search pointer
        logic park;          // put running slot back to ready
        logic start;         // start the found slot
        logic drop_run;      // return to main without a next task
        logic load_out;      // move result into the output register
    } rrts_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] act;
        logic       full;
        logic       empty;
        logic       run_valid;
        logic       q_in_range;
        logic       left_zero;
        logic       rd_ready;
        logic       alive_le1;
        logic       out_free;
    } rrts_sts_t;

endpackage

>>> rtl/rrts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ctrl
// Event sequencer: decodes each event and steps the datapath through slot
// reads, runtime charge, the ring search and the task start.
// ----------------------------------------------------------------------------
module rrts_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rrts_pkg::rrts_sts_t sts,
    output rrts_pkg::rrts_cmd_t cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_Q_WAIT   = 4'd2;
    localparam logic [3:0] S_CUR_WAIT = 4'd3;
    localparam logic [3:0] S_CHARGE   = 4'd4;
    localparam logic [3:0] S_SRCH_RD  = 4'd5;
    localparam logic [3:0] S_SRCH_CHK = 4'd6;
    localparam logic [3:0] S_PARK     = 4'd7;
    localparam logic [3:0] S_START    = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode next state and datapath commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (sts.act == rrts_pkg::ACT_CREATE)
                begin
                    if (sts.full)
                    begin
                        cmd.set_full = 1'b1;
                    end
                    else
                    begin
                        cmd.create = 1'b1;
                    end
                    state_next = S_DONE;
                end
                else if (sts.act == rrts_pkg::ACT_RUN)
                begin
                    if (sts.empty || sts.run_valid)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.srch_init_run = 1'b1;
                        state_next        = S_SRCH_RD;
                    end
                end
                else if (sts.act == rrts_pkg::ACT_YIELD || sts.act == rrts_pkg::ACT_EXIT)
                begin
                    if (!sts.run_valid)
                    begin
                        cmd.set_nocur = 1'b1;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        cmd.rd_cur = 1'b1;
                        state_next = S_CUR_WAIT;
                    end
                end
                else if (sts.act == rrts_pkg::ACT_QUERY && sts.q_in_range)
                begin
                    cmd.rd_q   = 1'b1;
                    state_next = S_Q_WAIT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_Q_WAIT:
            begin
                cmd.latch_q = 1'b1;
                state_next  = S_DONE;
            end
            S_CUR_WAIT:
            begin
                cmd.latch_cur = 1'b1;
                state_next    = S_CHARGE;
            end
            S_CHARGE:
            begin
                cmd.write_cur = 1'b1;
                if (sts.act == rrts_pkg::ACT_EXIT && sts.alive_le1)
                begin
                    cmd.exit_main = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.srch_init_cur = 1'b1;
                    state_next        = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                if (sts.left_zero)
                begin
                    // Nothing ready: run reports it, exit also returns to main
                    if (sts.act == rrts_pkg::ACT_RUN)
                    begin
                        cmd.set_noready = 1'b1;
                    end
                    else if (sts.act == rrts_pkg::ACT_EXIT)
                    begin
                        cmd.set_noready = 1'b1;
                        cmd.drop_run    = 1'b1;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK:
            begin
                if (sts.rd_ready)
                begin
                    state_next = (sts.act == rrts_pkg::ACT_YIELD) ? S_PARK : S_START;
                end
                else
                begin
                    cmd.srch_step = 1'b1;
                    state_next    = S_SRCH_RD;
                end
            end
            S_PARK:
            begin
                cmd.park   = 1'b1;
                state_next = S_START;
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/rrts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_dp
// Scheduler datapath: slot record memory, fill count, running slot, alive
// and switch counters, search pointer, runtime charge and result register.
// ----------------------------------------------------------------------------
module rrts_dp
#(
    parameter int MAX_TASKS = rrts_pkg::DEF_MAX_TASKS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rrts_pkg::rrts_cmd_t cmd,
    output rrts_pkg::rrts_sts_t sts,
    input  logic [2:0]          action,
    input  logic [31:0]         now_tick,
    input  logic [2:0]          query_index,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic signed [3:0]   current_task,
    output logic                switched,
    output logic [2:0]          created_slot,
    output logic                all_done,
    output logic [3:0]          alive_tasks,
    output logic [31:0]         switch_total,
    output logic [31:0]         query_switches,
    output logic [47:0]         query_runtime,
    output logic [1:0]          query_state
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // Slot record memory; entries at or above the fill count are never read
    rrts_pkg::slot_rec_t mem [MAX_TASKS];
    rrts_pkg::slot_rec_t rdata_reg;
    logic                mem_we;
    logic                mem_re;
    logic [IW-1:0]       mem_waddr;
    logic [IW-1:0]       mem_raddr;
    rrts_pkg::slot_rec_t mem_wdata;

    // Scheduler state
    logic [CW-1:0] task_count_reg;
    logic [CW-1:0] alive_reg;
    logic          run_valid_reg;
    logic [IW-1:0] run_idx_reg;
    logic [31:0]   total_reg;

    // Event and work registers
    logic [2:0]          act_reg;
    logic [31:0]         now_reg;
    logic [2:0]          qidx_reg;
    logic [IW-1:0]       srch_idx_reg;
    logic [CW-1:0]       srch_left_reg;
    rrts_pkg::slot_rec_t cur_rec_reg;
    logic [31:0]         diff_reg;
    logic                charge_en_reg;

    // Result staging
    logic [1:0]  res_status_reg;
    logic        res_switched_reg;
    logic [2:0]  res_created_reg;
    logic        res_done_reg;
    logic [31:0] res_qsw_reg;
    logic [47:0] res_qrt_reg;
    logic [1:0]  res_qst_reg;

    // Output register
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [3:0]  out_cur_reg;
    logic        out_switched_reg;
    logic [2:0]  out_created_reg;
    logic        out_done_reg;
    logic [3:0]  out_alive_reg;
    logic [31:0] out_total_reg;
    logic [31:0] out_qsw_reg;
    logic [47:0] out_qrt_reg;
    logic [1:0]  out_qst_reg;

    logic [CW-1:0] srch_inc;
    logic [IW-1:0] srch_wrap;
    logic [CW-1:0] cur_inc;
    logic [IW-1:0] cur_wrap;
    logic [48:0]   rt_sum;
    logic [47:0]   rt_next;
    logic [1:0]    cur_state_next;
    logic          out_free;

    // Ring increments modulo the fill count
    always_comb
    begin
        srch_inc  = CW'(srch_idx_reg) + CW'(1);
        srch_wrap = (srch_inc == task_count_reg) ? '0 : IW'(srch_inc);
        cur_inc   = CW'(run_idx_reg) + CW'(1);
        cur_wrap  = (cur_inc == task_count_reg) ? '0 : IW'(cur_inc);
    end

    // Charge the running slot, saturating at the 48-bit limit
    always_comb
    begin
        rt_sum  = {1'b0, cur_rec_reg.runtime} + 49'(diff_reg);
        rt_next = cur_rec_reg.runtime;
        if (charge_en_reg)
        begin
            rt_next = rt_sum[48] ? 48'hFFFF_FFFF_FFFF : rt_sum[47:0];
        end
        cur_state_next = (act_reg == rrts_pkg::ACT_EXIT) ? rrts_pkg::SLOT_FINISHED
                                                         : rrts_pkg::SLOT_RUNNING;
    end

    // Select memory read and write port
    always_comb
    begin
        mem_re    = cmd.rd_cur | cmd.rd_q | cmd.srch_rd;
        mem_raddr = srch_idx_reg;
        if (cmd.rd_cur)
        begin
            mem_raddr = run_idx_reg;
        end
        else if (cmd.rd_q)
        begin
            mem_raddr = IW'(qidx_reg);
        end

        mem_we    = cmd.create | cmd.write_cur | cmd.park | cmd.start;
        mem_waddr = run_idx_reg;
        mem_wdata = cur_rec_reg;
        priority if (cmd.create)
        begin
            mem_waddr            = task_count_reg[IW-1:0];
            mem_wdata            = '0;
            mem_wdata.state      = rrts_pkg::SLOT_READY;
        end
        else if (cmd.write_cur)
        begin
            mem_wdata.state   = cur_state_next;
            mem_wdata.runtime = rt_next;
        end
        else if (cmd.park)
        begin
            mem_wdata.state = rrts_pkg::SLOT_READY;
        end
        else if (cmd.start)
        begin
            mem_waddr            = srch_idx_reg;
            mem_wdata            = rdata_reg;
            mem_wdata.state      = rrts_pkg::SLOT_RUNNING;
            mem_wdata.switches   = sat_inc32(rdata_reg.switches);
            mem_wdata.start_tick = now_reg;
        end
    end

    // Write and read the slot memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Update scheduler control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= '0;
            alive_reg      <= '0;
            run_valid_reg  <= 1'b0;
            run_idx_reg    <= '0;
            total_reg      <= '0;
        end
        else
        begin
            if (cmd.create)
            begin
                task_count_reg <= task_count_reg + CW'(1);
                alive_reg      <= alive_reg + CW'(1);
            end
            if (cmd.write_cur && act_reg == rrts_pkg::ACT_EXIT && alive_reg != '0)
            begin
                alive_reg <= alive_reg - CW'(1);
            end
            if (cmd.exit_main || cmd.drop_run)
            begin
                run_valid_reg <= 1'b0;
            end
            if (cmd.start)
            begin
                run_valid_reg <= 1'b1;
                run_idx_reg   <= srch_idx_reg;
                total_reg     <= sat_inc32(total_reg);
            end
        end
    end

    // Capture the event and step the work registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg          <= action;
            now_reg          <= now_tick;
            qidx_reg         <= query_index;
            res_status_reg   <= rrts_pkg::STS_OK;
            res_switched_reg <= 1'b0;
            res_created_reg  <= '0;
            res_done_reg     <= 1'b0;
            res_qsw_reg      <= '0;
            res_qrt_reg      <= '0;
            res_qst_reg      <= rrts_pkg::SLOT_UNUSED;
        end
        if (cmd.set_full)
        begin
            res_status_reg <= rrts_pkg::STS_FULL;
        end
        if (cmd.set_nocur)
        begin
            res_status_reg <= rrts_pkg::STS_NOCUR;
        end
        if (cmd.set_noready)
        begin
            res_status_reg <= rrts_pkg::STS_NOREADY;
        end
        if (cmd.create)
        begin
            res_created_reg <= 3'(task_count_reg);
        end
        if (cmd.latch_q)
        begin
            res_qsw_reg <= rdata_reg.switches;
            res_qrt_reg <= rdata_reg.runtime;
            res_qst_reg <= rdata_reg.state;
        end
        if (cmd.latch_cur)
        begin
            cur_rec_reg   <= rdata_reg;
            diff_reg      <= now_reg - rdata_reg.start_tick;
            charge_en_reg <= (rdata_reg.start_tick != 32'd0);
        end
        if (cmd.write_cur)
        begin
            cur_rec_reg.runtime <= rt_next;
            cur_rec_reg.state   <= cur_state_next;
            if (act_reg == rrts_pkg::ACT_EXIT)
            begin
                res_switched_reg <= 1'b1;
            end
        end
        if (cmd.exit_main)
        begin
            res_done_reg <= 1'b1;
        end
        if (cmd.srch_init_run)
        begin
            srch_idx_reg  <= '0;
            srch_left_reg <= task_count_reg;
        end
        if (cmd.srch_init_cur)
        begin
            srch_idx_reg  <= cur_wrap;
            srch_left_reg <= task_count_reg - CW'(1);
        end
        if (cmd.srch_step)
        begin
            srch_idx_reg  <= srch_wrap;
            srch_left_reg <= srch_left_reg - CW'(1);
        end
        if (cmd.start)
        begin
            res_switched_reg <= 1'b1;
        end
    end

    // Hold the result until its transfer
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg   <= res_status_reg;
            out_cur_reg      <= run_valid_reg ? 4'(run_idx_reg) : 4'hF;
            out_switched_reg <= res_switched_reg;
            out_created_reg  <= res_created_reg;
            out_done_reg     <= res_done_reg;
            out_alive_reg    <= 4'(alive_reg);
            out_total_reg    <= total_reg;
            out_qsw_reg      <= res_qsw_reg;
            out_qrt_reg      <= res_qrt_reg;
            out_qst_reg      <= res_qst_reg;
        end
    end

    // Report status to the sequencer
    always_comb
    begin
        sts.act        = act_reg;
        sts.full       = (task_count_reg == CW'(MAX_TASKS));
        sts.empty      = (task_count_reg == '0);
        sts.run_valid  = run_valid_reg;
        sts.q_in_range = (8'(qidx_reg) < 8'(task_count_reg));
        sts.left_zero  = (srch_left_reg == '0);
        sts.rd_ready   = (rdata_reg.state == rrts_pkg::SLOT_READY);
        sts.alive_le1  = (alive_reg <= CW'(1));
        sts.out_free   = out_free;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign current_task   = out_cur_reg;
    assign switched       = out_switched_reg;
    assign created_slot   = out_created_reg;
    assign all_done       = out_done_reg;
    assign alive_tasks    = out_alive_reg;
    assign switch_total   = out_total_reg;
    assign query_switches = out_qsw_reg;
    assign query_runtime  = out_qrt_reg;
    assign query_state    = out_qst_reg;

endmodule

>>> rtl/round_robin_task_scheduler_top.sv
`timescale 1ns / 1ps
// Events: create, query and rejected events need no search; run, yield and exit may search the ring,
// reading and checking each slot visited, up to MAX_TASKS slots.
// Throughput: one event at a time; the next is taken as soon as its result is registered,
// set by the sequencer, which walks the slot memory (one read and one write port) in the ring search.
// Reset: asynchronous, clears fill count, running slot and counters; the slot memory
// needs no clearing pass since slots at or above the fill count are never read.
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_top
// Task table with a round-robin picker: create, run, yield, exit and query
// events, per-task switch and runtime statistics.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_top
#(
    parameter int MAX_TASKS = rrts_pkg::DEF_MAX_TASKS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        action,
    input  logic [31:0]       now_tick,
    input  logic [2:0]        query_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic signed [3:0] current_task,
    output logic              switched,
    output logic [2:0]        created_slot,
    output logic              all_done,
    output logic [3:0]        alive_tasks,
    output logic [31:0]       switch_total,
    output logic [31:0]       query_switches,
    output logic [47:0]       query_runtime,
    output logic [1:0]        query_state
);

    rrts_pkg::rrts_cmd_t cmd;
    rrts_pkg::rrts_sts_t sts;

    // Sequence each event
    rrts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the task table and produce results
    rrts_dp
    #(
        .MAX_TASKS (MAX_TASKS)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .action         (action),
        .now_tick       (now_tick),
        .query_index    (query_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .current_task   (current_task),
        .switched       (switched),
        .created_slot   (created_slot),
        .all_done       (all_done),
        .alive_tasks    (alive_tasks),
        .switch_total   (switch_total),
        .query_switches (query_switches),
        .query_runtime  (query_runtime),
        .query_state    (query_state)
    );

endmodule

>>> verif/rrts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_checker
// Watches both channels of the task scheduler, keeps its own copy of the
// task table to predict each event's outcome, and compares every result
// transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module rrts_checker
#(
    parameter int MAX_TASKS = rrts_pkg::DEF_MAX_TASKS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [2:0]        action,
    input  logic [31:0]       now_tick,
    input  logic [2:0]        query_index,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [1:0]        status,
    input  logic signed [3:0] current_task,
    input  logic              switched,
    input  logic [2:0]        created_slot,
    input  logic              all_done,
    input  logic [3:0]        alive_tasks,
    input  logic [31:0]       switch_total,
    input  logic [31:0]       query_switches,
    input  logic [47:0]       query_runtime,
    input  logic [1:0]        query_state,
    output int unsigned       fail_count,
    output int unsigned       outstanding
);

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  task_id;
        logic        switched;
        logic [2:0]  slot;
        logic        done;
        logic [3:0]  alive;
        logic [31:0] total;
        logic [31:0] q_switches;
        logic [47:0] q_runtime;
        logic [1:0]  q_state;
    } sched_outcome_t;

    // Predicted task table
    logic [1:0]  slot_state_r  [MAX_TASKS];
    logic [31:0] slot_switch_r [MAX_TASKS];
    logic [47:0] slot_ticks_r  [MAX_TASKS];
    logic [31:0] slot_since_r  [MAX_TASKS];
    int unsigned fill_level;
    int          running_id;
    int unsigned live_tasks;
    logic [31:0] switch_sum;

    sched_outcome_t outcome_q [$];
    sched_outcome_t want;

    function automatic logic [31:0] sat_bump(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    // First ready slot in ring order after origin, wrapping back to origin itself
    function automatic int ring_next_ready(input int unsigned origin);
        int unsigned idx;
        if (fill_level == 0 || fill_level > MAX_TASKS)
            return -1;
        for (int unsigned i = 1; i <= fill_level; i++)
        begin
            idx = (origin + i) % fill_level;
            if (slot_state_r[idx] == rrts_pkg::SLOT_READY)
                return int'(idx);
        end
        return -1;
    endfunction

    function automatic void launch(input int unsigned s, input logic [31:0] now);
        slot_state_r[s]  = rrts_pkg::SLOT_RUNNING;
        slot_switch_r[s] = sat_bump(slot_switch_r[s]);
        slot_since_r[s]  = now;
        running_id       = int'(s);
        switch_sum       = sat_bump(switch_sum);
    endfunction

    // Charge the wrapping tick span, only when the task has a nonzero start tick
    function automatic void bill_runtime(input int unsigned s, input logic [31:0] now);
        logic [31:0] span;
        logic [48:0] sum;
        if (slot_since_r[s] != '0)
        begin
            span            = now - slot_since_r[s];
            sum             = {1'b0, slot_ticks_r[s]} + {17'd0, span};
            slot_ticks_r[s] = sum[48] ? '1 : sum[47:0];
        end
    endfunction

    function automatic sched_outcome_t predict_event(input logic [2:0] act,
                                                     input logic [31:0] now,
                                                     input logic [2:0] qi);
        sched_outcome_t res;
        int             nxt;
        int unsigned    cur;
        res = '0;
        case (act)
            rrts_pkg::ACT_CREATE:
            begin
                if (fill_level >= MAX_TASKS)
                    res.status = rrts_pkg::STS_FULL;
                else
                begin
                    slot_state_r[fill_level]  = rrts_pkg::SLOT_READY;
                    slot_switch_r[fill_level] = '0;
                    slot_ticks_r[fill_level]  = '0;
                    slot_since_r[fill_level]  = '0;
                    res.slot                  = 3'(fill_level);
                    fill_level++;
                    live_tasks++;
                end
            end
            rrts_pkg::ACT_RUN:
            begin
                // ignored with an empty table or while a task runs
                if (fill_level != 0 && running_id < 0)
                begin
                    nxt = ring_next_ready(fill_level - 1);
                    if (nxt < 0)
                        res.status = rrts_pkg::STS_NOREADY;
                    else
                    begin
                        launch(nxt, now);
                        res.switched = 1'b1;
                    end
                end
            end
            rrts_pkg::ACT_YIELD, rrts_pkg::ACT_EXIT:
            begin
                if (running_id < 0 || running_id >= MAX_TASKS)
                    res.status = rrts_pkg::STS_NOCUR;
                else
                begin
                    cur = running_id;
                    bill_runtime(cur, now);
                    if (act == rrts_pkg::ACT_YIELD)
                    begin
                        // keep the running task, start tick untouched, if nobody else is ready
                        slot_state_r[cur] = rrts_pkg::SLOT_READY;
                        nxt = ring_next_ready(cur);
                        if (nxt < 0 || nxt == int'(cur))
                            slot_state_r[cur] = rrts_pkg::SLOT_RUNNING;
                        else
                        begin
                            launch(nxt, now);
                            res.switched = 1'b1;
                        end
                    end
                    else
                    begin
                        slot_state_r[cur] = rrts_pkg::SLOT_FINISHED;
                        if (live_tasks > 0)
                            live_tasks--;
                        res.switched = 1'b1;
                        if (live_tasks == 0)
                        begin
                            running_id = -1;
                            res.done   = 1'b1;
                        end
                        else
                        begin
                            nxt = ring_next_ready(cur);
                            if (nxt >= 0)
                                launch(nxt, now);
                            else
                            begin
                                running_id = -1;
                                res.status = rrts_pkg::STS_NOREADY;
                            end
                        end
                    end
                end
            end
            rrts_pkg::ACT_QUERY:
            begin
                if (qi < MAX_TASKS)
                begin
                    res.q_switches = slot_switch_r[qi];
                    res.q_runtime  = slot_ticks_r[qi];
                    res.q_state    = slot_state_r[qi];
                end
            end
            default:
            begin
            end
        endcase
        res.task_id = 4'(running_id);
        res.alive   = 4'(live_tasks);
        res.total   = switch_sum;
        return res;
    endfunction

    task automatic check_field(input string field, input logic [47:0] exp_val,
                               input logic [47:0] act_val);
        if (exp_val !== act_val)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, exp_val, act_val);
        end
    endtask

    // Predict on each event transfer, compare on each result transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_TASKS; k++)
            begin
                slot_state_r[k]  = rrts_pkg::SLOT_UNUSED;
                slot_switch_r[k] = '0;
                slot_ticks_r[k]  = '0;
                slot_since_r[k]  = '0;
            end
            fill_level  = 0;
            running_id  = -1;
            live_tasks  = 0;
            switch_sum  = '0;
            fail_count  = 0;
            outcome_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                outcome_q.push_back(predict_event(action, now_tick, query_index));
            if (out_valid && out_ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with no event pending, expected none, actual status %0d",
                             $time, status);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("status",         want.status,     status);
                    check_field("current_task",   want.task_id,    $unsigned(current_task));
                    check_field("switched",       want.switched,   switched);
                    check_field("created_slot",   want.slot,       created_slot);
                    check_field("all_done",       want.done,       all_done);
                    check_field("alive_tasks",    want.alive,      alive_tasks);
                    check_field("switch_total",   want.total,      switch_total);
                    check_field("query_switches", want.q_switches, query_switches);
                    check_field("query_runtime",  want.q_runtime,  query_runtime);
                    check_field("query_state",    want.q_state,    query_state);
                end
            end
            outstanding <= outcome_q.size();
        end
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives scheduling events into the task scheduler: a directed pass over the
// error cases, wrapping runtime and the full table, then random event streams
// weighted toward yields. Checking is done by rrts_checker.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned RANDOM_ITEMS = 1125;
    localparam int unsigned IDLE_PCT     = 9;
    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned DRAIN_CYCLES = 40;

    // Event codes the block does not decode
    localparam logic [2:0] ACT_SPARE_A = 3'd5;
    localparam logic [2:0] ACT_SPARE_C = 3'd7;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [2:0]        action;
    logic [31:0]       now_tick;
    logic [2:0]        query_index;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        status;
    logic signed [3:0] current_task;
    logic              switched;
    logic [2:0]        created_slot;
    logic              all_done;
    logic [3:0]        alive_tasks;
    logic [31:0]       switch_total;
    logic [31:0]       query_switches;
    logic [47:0]       query_runtime;
    logic [1:0]        query_state;

    logic              steady_phase;
    int unsigned       fail_count;
    int unsigned       outstanding;
    int unsigned       quiet_cycles = 0;

    round_robin_task_scheduler_top DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .now_tick       (now_tick),
        .query_index    (query_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .current_task   (current_task),
        .switched       (switched),
        .created_slot   (created_slot),
        .all_done       (all_done),
        .alive_tasks    (alive_tasks),
        .switch_total   (switch_total),
        .query_switches (query_switches),
        .query_runtime  (query_runtime),
        .query_state    (query_state)
    );

    rrts_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .now_tick       (now_tick),
        .query_index    (query_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .current_task   (current_task),
        .switched       (switched),
        .created_slot   (created_slot),
        .all_done       (all_done),
        .alive_tasks    (alive_tasks),
        .switch_total   (switch_total),
        .query_switches (query_switches),
        .query_runtime  (query_runtime),
        .query_state    (query_state),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: stall at random outside the steady stretch
    always @(posedge clk)
    begin
        out_ready <= steady_phase || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("FAIL round_robin_task_scheduler_top");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one event, with optional idle gaps first, and hold it until transfer
    task automatic issue_event(input logic [2:0] act, input logic [31:0] tick,
                               input logic [2:0] slot);
        while (!steady_phase && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        now_tick    <= tick;
        query_index <= slot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned counted;
        int unsigned roll;
        int unsigned exit_top;
        logic [2:0]  act;
        logic [31:0] tick;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        action       <= rrts_pkg::ACT_CREATE;
        now_tick     <= '0;
        query_index  <= '0;
        steady_phase <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Error cases from main context and on an empty table
        issue_event(rrts_pkg::ACT_YIELD, 32'h0, 3'd0);
        issue_event(rrts_pkg::ACT_EXIT, 32'hFFFF_FFFF, 3'd7);
        issue_event(rrts_pkg::ACT_RUN, 32'h1234_5678, 3'd0);
        issue_event(rrts_pkg::ACT_QUERY, 32'h0, 3'd7);
        issue_event(ACT_SPARE_C, 32'hFFFF_FFFF, 3'd7);
        // Two tasks; first starts at tick zero so its first slice is not charged
        issue_event(rrts_pkg::ACT_CREATE, 32'h0, 3'd0);
        issue_event(rrts_pkg::ACT_CREATE, 32'h0, 3'd0);
        issue_event(rrts_pkg::ACT_RUN, 32'h0, 3'd0);
        issue_event(rrts_pkg::ACT_RUN, 32'h1, 3'd0);
        issue_event(rrts_pkg::ACT_YIELD, 32'd5, 3'd0);
        // Tick going backward: wrapping span
        issue_event(rrts_pkg::ACT_YIELD, 32'd3, 3'd0);
        issue_event(rrts_pkg::ACT_EXIT, 32'hFFFF_FFFF, 3'd0);
        // Lone task yields twice: same start tick charged again
        issue_event(rrts_pkg::ACT_YIELD, 32'd7, 3'd0);
        issue_event(rrts_pkg::ACT_YIELD, 32'd9, 3'd0);
        issue_event(rrts_pkg::ACT_QUERY, 32'h0, 3'd0);
        issue_event(rrts_pkg::ACT_QUERY, 32'h0, 3'd1);
        // Last task exits, then run with nothing ready
        issue_event(rrts_pkg::ACT_EXIT, 32'd20, 3'd0);
        issue_event(rrts_pkg::ACT_RUN, 32'd21, 3'd0);
        // Fill the table, then overflow it
        repeat (6) issue_event(rrts_pkg::ACT_CREATE, 32'h0, 3'd0);
        issue_event(rrts_pkg::ACT_CREATE, 32'h0, 3'd0);
        issue_event(rrts_pkg::ACT_QUERY, 32'h0, 3'd2);

        // Random events: mostly yields, rare exits until the tail drains the table
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            steady_phase <= (counted >= 400 && counted < 600);
            roll     = $urandom_range(0, 999);
            exit_top = (counted + 80 >= RANDOM_ITEMS) ? 425 : 129;
            if (roll < 15)
                act = ACT_SPARE_A + 3'($urandom_range(0, 2));
            else if (roll < 45)
                act = rrts_pkg::ACT_CREATE;
            else if (roll < 125)
                act = rrts_pkg::ACT_RUN;
            else if (roll < exit_top)
                act = rrts_pkg::ACT_EXIT;
            else if (roll < 780)
                act = rrts_pkg::ACT_YIELD;
            else
                act = rrts_pkg::ACT_QUERY;
            roll = $urandom_range(0, 99);
            if (roll < 10)
                tick = '0;
            else if (roll < 15)
                tick = '1;
            else if (roll < 40)
                tick = 32'($urandom_range(0, 255));
            else
                tick = $urandom;
            issue_event(act, tick, 3'($urandom_range(0, 7)));
            if (act <= rrts_pkg::ACT_QUERY)
                counted++;
        end
        in_valid     <= 1'b0;
        steady_phase <= 1'b0;

        // Drain outstanding results, then give the verdict
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS round_robin_task_scheduler_top");
        else
            $display("FAIL round_robin_task_scheduler_top");
        $finish;
    end

endmodule
